// ----- rtl/hsi2rgb_pkg.sv -----
// hsi2rgb_pkg: shared widths, constants and types for the HSI to RGB converter.
// No dependencies; used by hsi_to_rgb_color_convert.
package hsi2rgb_pkg;

    // fixed word field widths
    localparam int HUE_W = 16;
    localparam int LVL_W = 18;
    localparam int OUT_W = 17;

    // hue wheel in whole degrees
    localparam int DEG_TURN = 360;
    localparam int DEG_SEXT = 60;

    // pipeline depth, input register to output register
    localparam int N_STG = 10;

    // sextant of the wrapped hue
    typedef enum logic [2:0] {
        SX_0 = 3'd0,
        SX_1 = 3'd1,
        SX_2 = 3'd2,
        SX_3 = 3'd3,
        SX_4 = 3'd4,
        SX_5 = 3'd5
    } t_sextant;

endpackage

// ----- rtl/hsi_to_rgb_color_convert.sv -----
// hsi_to_rgb_color_convert: pipelined hue/saturation/intensity to RGB converter.
// Depends on hsi2rgb_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word: signed hue in
//   2^-HUE_FRAC_BITS degree units plus signed saturation and intensity
//   (1.0 = 2^FRAC_BITS). Output channel (o_out_valid / i_out_ready) returns
//   one word per input: red, green, blue, 1.0 = 2^FRAC_BITS, 17 bits each.
//   Throughput is one word per cycle while the receiver does not stall: the
//   ten register stages each hold one word and advance together. Hue wrap
//   and the hue fraction use reciprocal multiplies with a one-step
//   correction; the saturation/intensity products use the multipliers in
//   S2, S8 and S9.
//   The final stage is the output register. When the receiver stalls with a
//   word waiting, the whole pipe holds and o_in_ready drops; bubbles are not
//   squeezed out. A stalled word is never lost or repeated.
//   Reset (synchronous, active low) clears all valid bits; the block keeps no
//   other state, so the pipe is empty and ready right after reset.
module hsi_to_rgb_color_convert #(
    parameter int FRAC_BITS     = 16,
    parameter int HUE_FRAC_BITS = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [hsi2rgb_pkg::HUE_W-1:0]   i_hue_angle,
    input  logic signed [hsi2rgb_pkg::LVL_W-1:0]   i_sat_level,
    input  logic signed [hsi2rgb_pkg::LVL_W-1:0]   i_int_level,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic        [hsi2rgb_pkg::OUT_W-1:0]   o_red,
    output logic        [hsi2rgb_pkg::OUT_W-1:0]   o_green,
    output logic        [hsi2rgb_pkg::OUT_W-1:0]   o_blue
);

    // ---------------------------------------------------------------
    // Derived constants
    // ---------------------------------------------------------------
    localparam int W_F   = FRAC_BITS;
    localparam int W_ONE = FRAC_BITS + 1;              // holds 1.0
    localparam logic [W_ONE-1:0] ONE_V = {1'b1, {W_F{1'b0}}};

    localparam int TURN = hsi2rgb_pkg::DEG_TURN << HUE_FRAC_BITS;
    localparam int SEXT = hsi2rgb_pkg::DEG_SEXT << HUE_FRAC_BITS;

    // hue is biased by a whole number of turns so it is never negative
    localparam int HUE_SPAN = 1 << (hsi2rgb_pkg::HUE_W - 1);
    localparam int OFFSET   = ((HUE_SPAN + TURN - 1) / TURN) * TURN;
    localparam int MAXU     = OFFSET + HUE_SPAN - 1;
    localparam int W_U      = $clog2(MAXU + 1);

    // turn count: q0 = (u * MT) >> W_U is floor(u/TURN) or one less
    localparam longint unsigned MT = (64'd1 << W_U) / TURN;
    localparam int W_MT = $clog2(MT + 1);
    localparam int W_Q  = $clog2(MAXU / TURN + 1);

    localparam int W_H1 = $clog2(2 * TURN);
    localparam int W_H  = $clog2(TURN);
    localparam int W_R  = $clog2(SEXT);

    // hue fraction: f0 = (rem * MF) >> W_R is floor(rem*ONE/SEXT) or one less
    localparam longint unsigned MF = (64'd1 << (W_F + W_R)) / SEXT;
    localparam int W_MF = $clog2(MF + 1);
    localparam int W_N  = W_R + W_F;

    localparam int W_CMP = (hsi2rgb_pkg::LVL_W - 1 > W_ONE) ?
                           hsi2rgb_pkg::LVL_W - 1 : W_ONE;
    localparam int W_PAD = (W_ONE > hsi2rgb_pkg::OUT_W) ? W_ONE : hsi2rgb_pkg::OUT_W;
    localparam int N_STG = hsi2rgb_pkg::N_STG;

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------
    function automatic logic [W_ONE-1:0] clamp_lvl(input logic signed [hsi2rgb_pkg::LVL_W-1:0] v);
        logic [W_CMP-1:0] mag;
        logic [W_ONE-1:0] res;
        mag = W_CMP'(v[hsi2rgb_pkg::LVL_W-2:0]);
        priority if (v[hsi2rgb_pkg::LVL_W-1]) begin
            res = '0;
        end else if (mag > W_CMP'(ONE_V)) begin
            res = ONE_V;
        end else begin
            res = W_ONE'(mag);
        end
        return res;
    endfunction

    // truncating fixed-point product, operands and result in 0..1.0
    function automatic logic [W_ONE-1:0] mul_fx(input logic [W_ONE-1:0] a,
                                                input logic [W_ONE-1:0] b);
        logic [2*W_ONE-1:0] p;
        p = (2*W_ONE)'(a) * (2*W_ONE)'(b);
        return W_ONE'(p >> W_F);
    endfunction

    function automatic logic [hsi2rgb_pkg::OUT_W-1:0] to_out(input logic [W_ONE-1:0] v);
        logic [W_PAD-1:0] pad;
        pad = W_PAD'(v);
        return pad[hsi2rgb_pkg::OUT_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Flow control: all stages advance together
    // ---------------------------------------------------------------
    logic             w_adv;
    logic [N_STG-1:0] r_vld;

    assign w_adv       = ~r_vld[N_STG-1] | i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_vld[N_STG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[N_STG-2:0], i_in_valid};
        end
    end

    // ---------------------------------------------------------------
    // Stage registers
    // ---------------------------------------------------------------
    // S1: bias hue, clamp S and I
    logic [W_U-1:0]   r_s1_u,   n_s1_u;
    logic [W_ONE-1:0] r_s1_s,   n_s1_s;
    logic [W_ONE-1:0] r_s1_i,   n_s1_i;
    logic [W_ONE-1:0] r_s1_oms, n_s1_oms;
    logic             r_s1_grey, n_s1_grey;
    // S2: turn estimate, c1
    logic [W_Q-1:0]   r_s2_q, n_s2_q;
    logic [W_U-1:0]   r_s2_u;
    logic [W_ONE-1:0] r_s2_s, r_s2_i;
    logic [W_ONE-1:0] r_s2_c1, n_s2_c1;
    logic             r_s2_grey;
    logic [W_U+W_MT-1:0] s2_prod;
    // S3: partial wrap
    logic [W_H1-1:0]  r_s3_h1, n_s3_h1;
    logic [W_ONE-1:0] r_s3_s, r_s3_i, r_s3_c1;
    logic             r_s3_grey;
    // S4: wrapped hue
    logic [W_H-1:0]   r_s4_h, n_s4_h;
    logic [W_ONE-1:0] r_s4_s, r_s4_i, r_s4_c1;
    logic             r_s4_grey;
    // S5: sextant and remainder
    hsi2rgb_pkg::t_sextant r_s5_sx, n_s5_sx;
    logic [W_R-1:0]   r_s5_rem, n_s5_rem;
    logic [W_ONE-1:0] r_s5_s, r_s5_i, r_s5_c1;
    logic             r_s5_grey;
    // S6: fraction estimate
    logic [W_F-1:0]   r_s6_f0, n_s6_f0;
    logic [W_R-1:0]   r_s6_rem;
    hsi2rgb_pkg::t_sextant r_s6_sx;
    logic [W_ONE-1:0] r_s6_s, r_s6_i, r_s6_c1;
    logic             r_s6_grey;
    logic [W_R+W_MF-1:0] s6_prod;
    // S7: exact fraction
    logic [W_F-1:0]   r_s7_f, n_s7_f;
    logic [W_N-1:0]   s7_chk;
    hsi2rgb_pkg::t_sextant r_s7_sx;
    logic [W_ONE-1:0] r_s7_s, r_s7_i, r_s7_c1;
    logic             r_s7_grey;
    // S8: 1 - S*f and 1 - S*(1-f)
    logic [W_ONE-1:0] r_s8_a, n_s8_a;
    logic [W_ONE-1:0] r_s8_b, n_s8_b;
    hsi2rgb_pkg::t_sextant r_s8_sx;
    logic [W_ONE-1:0] r_s8_i, r_s8_c1;
    logic             r_s8_grey;
    // S9: c2, c3
    logic [W_ONE-1:0] r_s9_c2, n_s9_c2;
    logic [W_ONE-1:0] r_s9_c3, n_s9_c3;
    hsi2rgb_pkg::t_sextant r_s9_sx;
    logic [W_ONE-1:0] r_s9_i, r_s9_c1;
    logic             r_s9_grey;
    // S10: output register
    logic [hsi2rgb_pkg::OUT_W-1:0] r_s10_r, n_s10_r;
    logic [hsi2rgb_pkg::OUT_W-1:0] r_s10_g, n_s10_g;
    logic [hsi2rgb_pkg::OUT_W-1:0] r_s10_b, n_s10_b;
    logic             r_s10_grey;

    // ---------------------------------------------------------------
    // Stage logic
    // ---------------------------------------------------------------
    always_comb begin
        // S1
        n_s1_u    = W_U'(i_hue_angle) + W_U'(OFFSET);
        n_s1_s    = clamp_lvl(i_sat_level);
        n_s1_i    = clamp_lvl(i_int_level);
        n_s1_oms  = ONE_V - n_s1_s;
        n_s1_grey = (n_s1_s == '0);

        // S2: reciprocal multiply for the turn count; c1 = I(1-S) alongside
        s2_prod = (W_U+W_MT)'(r_s1_u) * (W_U+W_MT)'(MT);
        n_s2_q  = W_Q'(s2_prod >> W_U);
        n_s2_c1 = mul_fx(r_s1_i, r_s1_oms);

        // S3: u - q0*TURN lands in 0 .. 2*TURN-1
        n_s3_h1 = W_H1'(r_s2_u - W_U'(W_U'(r_s2_q) * W_U'(TURN)));

        // S4: one conditional subtract finishes the wrap
        n_s4_h = (r_s3_h1 >= W_H1'(TURN)) ? W_H'(r_s3_h1 - W_H1'(TURN)) : W_H'(r_s3_h1);

        // S5: sextant by threshold compare
        priority if (r_s4_h >= W_H'(5 * SEXT)) begin
            n_s5_sx  = hsi2rgb_pkg::SX_5;
            n_s5_rem = W_R'(r_s4_h - W_H'(5 * SEXT));
        end else if (r_s4_h >= W_H'(4 * SEXT)) begin
            n_s5_sx  = hsi2rgb_pkg::SX_4;
            n_s5_rem = W_R'(r_s4_h - W_H'(4 * SEXT));
        end else if (r_s4_h >= W_H'(3 * SEXT)) begin
            n_s5_sx  = hsi2rgb_pkg::SX_3;
            n_s5_rem = W_R'(r_s4_h - W_H'(3 * SEXT));
        end else if (r_s4_h >= W_H'(2 * SEXT)) begin
            n_s5_sx  = hsi2rgb_pkg::SX_2;
            n_s5_rem = W_R'(r_s4_h - W_H'(2 * SEXT));
        end else if (r_s4_h >= W_H'(SEXT)) begin
            n_s5_sx  = hsi2rgb_pkg::SX_1;
            n_s5_rem = W_R'(r_s4_h - W_H'(SEXT));
        end else begin
            n_s5_sx  = hsi2rgb_pkg::SX_0;
            n_s5_rem = W_R'(r_s4_h);
        end

        // S6: fraction estimate
        s6_prod = (W_R+W_MF)'(r_s5_rem) * (W_R+W_MF)'(MF);
        n_s6_f0 = W_F'(s6_prod >> W_R);

        // S7: bump the estimate if the remainder is still a full sextant
        s7_chk = {r_s6_rem, {W_F{1'b0}}} - W_N'(W_N'(r_s6_f0) * W_N'(SEXT));
        n_s7_f = (s7_chk >= W_N'(SEXT)) ? r_s6_f0 + W_F'(1) : r_s6_f0;

        // S8
        n_s8_a = ONE_V - mul_fx(r_s7_s, W_ONE'(r_s7_f));
        n_s8_b = ONE_V - mul_fx(r_s7_s, ONE_V - W_ONE'(r_s7_f));

        // S9
        n_s9_c2 = mul_fx(r_s8_i, r_s8_a);
        n_s9_c3 = mul_fx(r_s8_i, r_s8_b);

        // S10: route candidates; hue 0 is blue, 120 red, 240 green
        if (r_s9_grey) begin
            n_s10_r = to_out(r_s9_i);
            n_s10_g = to_out(r_s9_i);
            n_s10_b = to_out(r_s9_i);
        end else begin
            unique case (r_s9_sx)
                hsi2rgb_pkg::SX_0: begin
                    n_s10_r = to_out(r_s9_c3);
                    n_s10_g = to_out(r_s9_c1);
                    n_s10_b = to_out(r_s9_i);
                end
                hsi2rgb_pkg::SX_1: begin
                    n_s10_r = to_out(r_s9_i);
                    n_s10_g = to_out(r_s9_c1);
                    n_s10_b = to_out(r_s9_c2);
                end
                hsi2rgb_pkg::SX_2: begin
                    n_s10_r = to_out(r_s9_i);
                    n_s10_g = to_out(r_s9_c3);
                    n_s10_b = to_out(r_s9_c1);
                end
                hsi2rgb_pkg::SX_3: begin
                    n_s10_r = to_out(r_s9_c2);
                    n_s10_g = to_out(r_s9_i);
                    n_s10_b = to_out(r_s9_c1);
                end
                hsi2rgb_pkg::SX_4: begin
                    n_s10_r = to_out(r_s9_c1);
                    n_s10_g = to_out(r_s9_i);
                    n_s10_b = to_out(r_s9_c3);
                end
                default: begin
                    n_s10_r = to_out(r_s9_c1);
                    n_s10_g = to_out(r_s9_c2);
                    n_s10_b = to_out(r_s9_i);
                end
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_u     <= n_s1_u;
            r_s1_s     <= n_s1_s;
            r_s1_i     <= n_s1_i;
            r_s1_oms   <= n_s1_oms;
            r_s1_grey  <= n_s1_grey;

            r_s2_q     <= n_s2_q;
            r_s2_u     <= r_s1_u;
            r_s2_s     <= r_s1_s;
            r_s2_i     <= r_s1_i;
            r_s2_c1    <= n_s2_c1;
            r_s2_grey  <= r_s1_grey;

            r_s3_h1    <= n_s3_h1;
            r_s3_s     <= r_s2_s;
            r_s3_i     <= r_s2_i;
            r_s3_c1    <= r_s2_c1;
            r_s3_grey  <= r_s2_grey;

            r_s4_h     <= n_s4_h;
            r_s4_s     <= r_s3_s;
            r_s4_i     <= r_s3_i;
            r_s4_c1    <= r_s3_c1;
            r_s4_grey  <= r_s3_grey;

            r_s5_sx    <= n_s5_sx;
            r_s5_rem   <= n_s5_rem;
            r_s5_s     <= r_s4_s;
            r_s5_i     <= r_s4_i;
            r_s5_c1    <= r_s4_c1;
            r_s5_grey  <= r_s4_grey;

            r_s6_f0    <= n_s6_f0;
            r_s6_rem   <= r_s5_rem;
            r_s6_sx    <= r_s5_sx;
            r_s6_s     <= r_s5_s;
            r_s6_i     <= r_s5_i;
            r_s6_c1    <= r_s5_c1;
            r_s6_grey  <= r_s5_grey;

            r_s7_f     <= n_s7_f;
            r_s7_sx    <= r_s6_sx;
            r_s7_s     <= r_s6_s;
            r_s7_i     <= r_s6_i;
            r_s7_c1    <= r_s6_c1;
            r_s7_grey  <= r_s6_grey;

            r_s8_a     <= n_s8_a;
            r_s8_b     <= n_s8_b;
            r_s8_sx    <= r_s7_sx;
            r_s8_i     <= r_s7_i;
            r_s8_c1    <= r_s7_c1;
            r_s8_grey  <= r_s7_grey;

            r_s9_c2    <= n_s9_c2;
            r_s9_c3    <= n_s9_c3;
            r_s9_sx    <= r_s8_sx;
            r_s9_i     <= r_s8_i;
            r_s9_c1    <= r_s8_c1;
            r_s9_grey  <= r_s8_grey;

            r_s10_r    <= n_s10_r;
            r_s10_g    <= n_s10_g;
            r_s10_b    <= n_s10_b;
            r_s10_grey <= r_s9_grey;
        end
    end

    assign o_red   = r_s10_r;
    assign o_green = r_s10_g;
    assign o_blue  = r_s10_b;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // accepted word shows up in the first stage
    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted word missing from stage 1");

    // hue wrap lands inside one turn
    a_hue_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r_s4_h < W_H'(TURN)))
        else $error("wrapped hue out of range");

    // fraction estimate is off by at most one
    a_frac_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (s7_chk < W_N'(2 * SEXT)))
        else $error("hue fraction estimate off by more than one");

    // grey words come out with equal channels
    a_grey_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_s10_grey) |-> (o_red == o_green && o_green == o_blue))
        else $error("grey word with unequal channels");

endmodule

// ----- dv/tb.sv -----
// tb: self-checking testbench for hsi_to_rgb_color_convert (HSI triple in, RGB triple out).
// Depends on hsi2rgb_pkg and the converter RTL; has its own fixed-point model of the
// conversion and a scoreboard of expected colors.
module tb;

    // Block configuration under test (RTL defaults)
    localparam int    FRAC_BITS     = 16;
    localparam int    HUE_FRAC_BITS = 4;
    localparam int    HUE_W         = hsi2rgb_pkg::HUE_W;
    localparam int    LVL_W         = hsi2rgb_pkg::LVL_W;
    localparam int    OUT_W         = hsi2rgb_pkg::OUT_W;
    localparam int    N_STG         = hsi2rgb_pkg::N_STG;
    localparam longint UNIT         = longint'(1) << FRAC_BITS;     // 1.0
    localparam longint TURN         = longint'(hsi2rgb_pkg::DEG_TURN) << HUE_FRAC_BITS;
    localparam longint SEXT         = longint'(hsi2rgb_pkg::DEG_SEXT) << HUE_FRAC_BITS;
    localparam int    N_RANDOM      = 1950;
    localparam int    MAX_REPORTS   = 10;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [LVL_W-1:0] sat;
        logic [LVL_W-1:0] lvl;
    } t_hsi_word;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } t_rgb_word;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic signed [HUE_W-1:0]  i_hue_angle;
    logic signed [LVL_W-1:0]  i_sat_level;
    logic signed [LVL_W-1:0]  i_int_level;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic        [OUT_W-1:0]  o_red;
    logic        [OUT_W-1:0]  o_green;
    logic        [OUT_W-1:0]  o_blue;

    hsi_to_rgb_color_convert #(
        .FRAC_BITS     (FRAC_BITS),
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_hue_angle (i_hue_angle),
        .i_sat_level (i_sat_level),
        .i_int_level (i_int_level),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    // Words waiting to be driven, and colors waiting to come out
    t_hsi_word hsi_pending[$];
    t_rgb_word rgb_expected[$];

    int n_mismatch  = 0;
    int n_errors    = 0;
    int n_accepted  = 0;
    int n_checked   = 0;
    int n_grey      = 0;
    int n_wrapped   = 0;
    int n_clamped   = 0;

    // Driver state: burst/gap shaping of the input side
    logic in_taken = 1'b0;  // word on the input port was accepted at the last edge
    int   burst_left = 1;
    int   gap_left   = 0;

    // Receiver state: stall pattern of the output side
    int stall_mode = 0;
    int mode_left  = 0;
    int stall_tick = 0;

    //------------------------------------------------------------------
    // Color model
    //------------------------------------------------------------------

    // Saturation / intensity clamp to 0..1.0
    function automatic longint clamp_unit(input logic signed [LVL_W-1:0] x);
        if (x < 0)
            return 0;
        if (longint'(x) > UNIT)
            return UNIT;
        return longint'(x);
    endfunction

    // Truncating fixed-point product; operands are never negative here
    function automatic longint fx_scale(input longint a, input longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic t_rgb_word rgb_from_hsi(input t_hsi_word w);
        longint    h;
        longint    rem;
        longint    s;
        longint    v;
        longint    f;
        longint    c1;
        longint    c2;
        longint    c3;
        logic [OUT_W-1:0] q1;
        logic [OUT_W-1:0] q2;
        logic [OUT_W-1:0] q3;
        logic [OUT_W-1:0] qv;
        hsi2rgb_pkg::t_sextant sx;
        t_rgb_word c;
        s = clamp_unit($signed(w.sat));
        v = clamp_unit($signed(w.lvl));
        qv = v[OUT_W-1:0];
        c.red   = qv;
        c.green = qv;
        c.blue  = qv;
        if (s != 0) begin
            // wrap hue into one turn; % truncates toward zero
            h = longint'($signed(w.hue)) % TURN;
            if (h < 0)
                h = h + TURN;
            sx  = hsi2rgb_pkg::t_sextant'(h / SEXT);
            rem = h - (h / SEXT) * SEXT;
            f   = (rem << FRAC_BITS) / SEXT;
            c1  = fx_scale(v, UNIT - s);
            c2  = fx_scale(v, UNIT - fx_scale(s, f));
            c3  = fx_scale(v, UNIT - fx_scale(s, UNIT - f));
            q1  = c1[OUT_W-1:0];
            q2  = c2[OUT_W-1:0];
            q3  = c3[OUT_W-1:0];
            // wheel is rotated: hue 0 blue, 120 red, 240 green
            case (sx)
                hsi2rgb_pkg::SX_0: begin c.red = q3; c.green = q1; c.blue = qv; end
                hsi2rgb_pkg::SX_1: begin c.red = qv; c.green = q1; c.blue = q2; end
                hsi2rgb_pkg::SX_2: begin c.red = qv; c.green = q3; c.blue = q1; end
                hsi2rgb_pkg::SX_3: begin c.red = q2; c.green = qv; c.blue = q1; end
                hsi2rgb_pkg::SX_4: begin c.red = q1; c.green = qv; c.blue = q3; end
                default: begin c.red = q1; c.green = q2; c.blue = qv; end
            endcase
        end
        return c;
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    function automatic t_hsi_word hsi_word(input int hue, input int sat, input int lvl);
        t_hsi_word w;
        w.hue = hue[HUE_W-1:0];
        w.sat = sat[LVL_W-1:0];
        w.lvl = lvl[LVL_W-1:0];
        return w;
    endfunction

    // Level with weight on the legal range, its edges, and out-of-range codes
    function automatic int rand_level(input bit sat_like);
        int pick;
        pick = $urandom_range(0, 11);
        case (pick)
            0:       return sat_like ? 0 : $urandom_range(0, 16);
            1, 2:    return int'($signed($urandom_range(0, (1 << LVL_W) - 1) << (32 - LVL_W)))
                            >>> (32 - LVL_W);
            3:       return int'(UNIT);
            4:       return $urandom_range(1, 40);
            5:       return int'(UNIT) - $urandom_range(0, 40);
            default: return $urandom_range(0, int'(UNIT));
        endcase
    endfunction

    function automatic int rand_hue();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            // near a sextant or turn boundary, either sign
            return ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, 34) * int'(SEXT)
                   + $urandom_range(0, 2) - 1;
        end
        return int'($signed($urandom_range(0, (1 << HUE_W) - 1) << (32 - HUE_W)))
               >>> (32 - HUE_W);
    endfunction

    task automatic check_field(input string tag, input logic [OUT_W-1:0] exp_v,
                               input logic [OUT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
                $display("tb: %s mismatch on word %0d: expected %0d, got %0d",
                         tag, n_checked, exp_v, act_v);
        end
    endtask

    //------------------------------------------------------------------
    // Clock
    //------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    //------------------------------------------------------------------
    // Scoreboard, sampled at the rising edge.
    // Input side: each accepted word is run through the color model and the
    // result queued. Output side: each accepted color is checked in order.
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rgb_expected.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("tb: unexpected output word r=%0d g=%0d b=%0d",
                             o_red, o_green, o_blue);
            end else begin
                t_rgb_word exp_c;
                exp_c = rgb_expected.pop_front();
                check_field("red",   exp_c.red,   o_red);
                check_field("green", exp_c.green, o_green);
                check_field("blue",  exp_c.blue,  o_blue);
                n_checked++;
            end
        end

        if (i_rst_n && i_in_valid && o_in_ready) begin
            t_hsi_word w;
            w = {i_hue_angle, i_sat_level, i_int_level};
            rgb_expected.push_back(rgb_from_hsi(w));
            n_accepted++;
            if (clamp_unit(i_sat_level) == 0)
                n_grey++;
            if (i_hue_angle < 0 || longint'(i_hue_angle) >= TURN)
                n_wrapped++;
            if (i_sat_level < 0 || longint'(i_sat_level) > UNIT ||
                i_int_level < 0 || longint'(i_int_level) > UNIT)
                n_clamped++;
            in_taken <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    //------------------------------------------------------------------
    // Input driver, falling edge. A presented word holds until accepted;
    // between bursts of random length the sender idles for random gaps.
    //------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // still waiting for the handshake: hold valid and payload
        end else if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            i_in_valid <= 1'b0;
        end else if (hsi_pending.size() == 0) begin
            i_in_valid <= 1'b0;
        end else begin
            {i_hue_angle, i_sat_level, i_int_level} <= hsi_pending.pop_front();
            i_in_valid <= 1'b1;
            if (burst_left <= 1) begin
                // long gap-free runs now and then, short choppy ones otherwise
                if ($urandom_range(0, 3) == 0) begin
                    burst_left <= $urandom_range(50, 200);
                    gap_left   <= 0;
                end else begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= $urandom_range(0, 1) ? $urandom_range(1, 4)
                                                       : $urandom_range(0, 15);
                end
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    //------------------------------------------------------------------
    // Output receiver, falling edge. Cycles through stall modes: always
    // ready, coin flip, periodic one-in-four stall, and mostly stalled.
    //------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(30, 250);
        end else begin
            mode_left <= mode_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 1) == 0);
            2:       i_out_ready <= (stall_tick % 4) != 3;
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_hue_angle = '0;
        i_sat_level = '0;
        i_int_level = '0;

        // Directed words: sextant starts and ends, hue wrap both ways,
        // clamping on both sides, grey, tiny saturation, zero intensity.
        for (int k = 0; k < 6; k++)
            hsi_pending.push_back(hsi_word(k * int'(SEXT), int'(UNIT), int'(UNIT)));
        hsi_pending.push_back(hsi_word(int'(SEXT) - 1, int'(UNIT), int'(UNIT)));
        hsi_pending.push_back(hsi_word(int'(TURN) - 1, int'(UNIT), int'(UNIT)));
        hsi_pending.push_back(hsi_word(int'(TURN), int'(UNIT), 40000));
        hsi_pending.push_back(hsi_word(-1, int'(UNIT), int'(UNIT)));
        hsi_pending.push_back(hsi_word(-int'(TURN), int'(UNIT), int'(UNIT)));
        hsi_pending.push_back(hsi_word(-32768, 50000, 30000));
        hsi_pending.push_back(hsi_word(32767, 50000, 30000));
        hsi_pending.push_back(hsi_word(480, 0, 40000));
        hsi_pending.push_back(hsi_word(480, -131072, 131071));
        hsi_pending.push_back(hsi_word(480, 131071, -131072));
        hsi_pending.push_back(hsi_word(1000, int'(UNIT) + 1, int'(UNIT) + 1));
        hsi_pending.push_back(hsi_word(1000, -1, -1));
        hsi_pending.push_back(hsi_word(2000, 1, int'(UNIT)));
        hsi_pending.push_back(hsi_word(3000, 32768, 0));
        hsi_pending.push_back(hsi_word(4321, 65535, 65535));

        // Random words
        for (int k = 0; k < N_RANDOM; k++)
            hsi_pending.push_back(hsi_word(rand_hue(), rand_level(1'b1), rand_level(1'b0)));

        // Hold reset, then release it on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything sent, everything back, then a quiet tail
        while (hsi_pending.size() != 0 || (i_in_valid && !in_taken))
            @(posedge i_clk);
        while (rgb_expected.size() != 0)
            @(posedge i_clk);
        repeat (N_STG * 4) @(posedge i_clk);

        if (rgb_expected.size() != 0)
            n_errors++;

        $display("tb: %0d words converted and checked; %0d grey, %0d with wrapped hue,",
                 n_checked, n_grey, n_wrapped);
        $display("tb: %0d with clamped levels; %0d field mismatches, %0d other errors",
                 n_clamped, n_mismatch, n_errors);
        if (n_mismatch == 0 && n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule
